// File: rtl/core/block_bitmap_allocator_assert.svh
// Assertion macros for the block bitmap allocator checker
`ifndef BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH
`define BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define BBAL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BBAL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/bbal_pkg.sv
// Shared types and constants of the block bitmap allocator
`default_nettype none

package bbal_pkg;

  localparam int IDX_W      = 12;
  localparam int CNT_W      = 13;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int INDEX_SPAN = 4096;

  localparam logic [CNT_W-1:0] TOTAL_RST    = 13'd4096;
  localparam logic [CNT_W-1:0] RESERVED_RST = 13'd0;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE,
    OP_READ,
    OP_ALLOC,
    OP_INIT
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOTAL,
    REG_RESERVED
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLR,
    ST_SEEK,
    ST_RMW,
    ST_SCAN
  } state_t;

endpackage

`default_nettype wire

// File: rtl/core/block_bitmap_allocator.sv
// First-fit block allocator over a one-bit-per-block usage map
//
//   channel  | ports                                            | handshake
//   ---------+--------------------------------------------------+--------------------------
//   request  | in_op, in_block_index, in_bit_value              | start & !busy
//   result   | out_status, out_bit_out, out_allocated_block,    | out_valid, one cycle
//            | out_free_blocks                                  |
//   config   | cfg_index, cfg_wdata                             | cfg_we
//
// Write/read: walks one word per cycle to the word holding the block, then accesses it.
// Allocate: scans for the first word with a free block; a zero count fails without a scan.
// Initialize: writes every map word, one per cycle, through the single write port.
// Reset runs the clear sweep (busy high), reserving nothing; results cannot be stalled.
`default_nettype none

module block_bitmap_allocator #(
  parameter int NUM_BLOCKS    = 4096,
  parameter int MAP_WORD_BITS = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [bbal_pkg::OP_W-1:0]       in_op,
  input  wire logic [bbal_pkg::IDX_W-1:0]      in_block_index,
  input  wire logic                            in_bit_value,
  output logic                                 out_valid,
  output logic                                 out_status,
  output logic                                 out_bit_out,
  output logic [bbal_pkg::IDX_W-1:0]           out_allocated_block,
  output logic [bbal_pkg::CNT_W-1:0]           out_free_blocks,
  input  wire logic                            cfg_we,
  input  wire logic [bbal_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bbal_pkg::CNT_W-1:0]      cfg_wdata
);

  localparam int MAP_BLOCKS = (NUM_BLOCKS < bbal_pkg::INDEX_SPAN) ? NUM_BLOCKS
                                                                 : bbal_pkg::INDEX_SPAN;
  localparam int MAP_WORDS  = (MAP_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int WW         = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BP_W       = $clog2(MAP_WORD_BITS);
  localparam int CW         = bbal_pkg::CNT_W;
  localparam int IW         = bbal_pkg::IDX_W;

  localparam logic [CW-1:0] MWB_C        = CW'(MAP_WORD_BITS);
  localparam logic [CW-1:0] MAP_BLOCKS_C = CW'(MAP_BLOCKS);
  localparam logic [WW-1:0] LAST_WORD    = WW'(MAP_WORDS - 1);

  bbal_pkg::state_t state_r, state_nxt;
  bbal_pkg::op_t    op_r, op_nxt;

  logic [WW-1:0]            iss_w_r, iss_w_nxt;
  logic [CW-1:0]            iss_base_r, iss_base_nxt;
  logic [WW-1:0]            chk_w_r, chk_w_nxt;
  logic [CW-1:0]            chk_base_r, chk_base_nxt;
  logic                     chk_vld_r, chk_vld_nxt;
  logic [IW-1:0]            idx_r, idx_nxt;
  logic                     val_r, val_nxt;
  logic [CW-1:0]            res_r, res_nxt;
  logic [CW-1:0]            fc_r, fc_nxt;
  logic                     emit_r, emit_nxt;
  logic [CW-1:0]            total_r;
  logic [CW-1:0]            rsv_r;

  logic                     out_valid_r, out_valid_nxt;
  logic                     out_status_r, out_status_nxt;
  logic                     out_bit_r, out_bit_nxt;
  logic [IW-1:0]            out_grant_r, out_grant_nxt;
  logic [CW-1:0]            out_free_r, out_free_nxt;

  logic [MAP_WORD_BITS-1:0] map_r [MAP_WORDS];
  logic [MAP_WORD_BITS-1:0] rdata_r;
  logic                     mem_we;
  logic [WW-1:0]            mem_waddr;
  logic [WW-1:0]            mem_raddr;
  logic [MAP_WORD_BITS-1:0] mem_wdata;

  logic [CW-1:0]            size;
  logic [CW-1:0]            res_lim;
  logic [CW-1:0]            scan_avail;
  logic [CW-1:0]            clr_avail;
  logic [MAP_WORD_BITS-1:0] scan_mask;
  logic [MAP_WORD_BITS-1:0] clr_mask;
  logic [MAP_WORD_BITS-1:0] free_vec;
  logic [MAP_WORD_BITS-1:0] set_word;
  logic [MAP_WORD_BITS-1:0] rmw_word;
  logic [CW-1:0]            bp_full;
  logic [BP_W-1:0]          bp;
  logic                     ffz_found;
  logic [BP_W-1:0]          ffz_pos;
  logic                     last_word;
  logic                     chk_last;

  bbal_ffz #(
    .WIDTH (MAP_WORD_BITS)
  ) u_ffz (
    .vec   (free_vec),
    .found (ffz_found),
    .pos   (ffz_pos)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_r[mem_waddr] <= mem_wdata;
    end
    rdata_r <= map_r[mem_raddr];
  end

  always_comb begin
    size       = (total_r > MAP_BLOCKS_C) ? MAP_BLOCKS_C : total_r;
    res_lim    = (rsv_r > size) ? size : rsv_r;
    scan_avail = (size > chk_base_r) ? size - chk_base_r : '0;
    clr_avail  = (res_r > iss_base_r) ? res_r - iss_base_r : '0;
    for (int b = 0; b < MAP_WORD_BITS; b++) begin
      scan_mask[b] = CW'(b) < scan_avail;
      clr_mask[b]  = CW'(b) < clr_avail;
    end
    free_vec = ~rdata_r & scan_mask;
    for (int b = 0; b < MAP_WORD_BITS; b++) begin
      set_word[b] = rdata_r[b] | (BP_W'(b) == ffz_pos);
    end
    bp_full       = {1'b0, idx_r} - iss_base_r;
    bp            = bp_full[BP_W-1:0];
    rmw_word      = rdata_r;
    rmw_word[bp]  = val_r;
    last_word     = iss_w_r == LAST_WORD;
    chk_last      = (chk_base_r + MWB_C) >= size;
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    iss_w_nxt      = iss_w_r;
    iss_base_nxt   = iss_base_r;
    chk_w_nxt      = chk_w_r;
    chk_base_nxt   = chk_base_r;
    chk_vld_nxt    = chk_vld_r;
    idx_nxt        = idx_r;
    val_nxt        = val_r;
    res_nxt        = res_r;
    fc_nxt         = fc_r;
    emit_nxt       = emit_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_bit_nxt    = out_bit_r;
    out_grant_nxt  = out_grant_r;
    out_free_nxt   = out_free_r;
    mem_we         = 1'b0;
    mem_waddr      = iss_w_r;
    mem_raddr      = iss_w_r;
    mem_wdata      = rdata_r;

    case (state_r)
      bbal_pkg::ST_IDLE: begin
        if (start) begin
          op_nxt       = bbal_pkg::op_t'(in_op);
          idx_nxt      = in_block_index;
          val_nxt      = in_bit_value;
          iss_w_nxt    = '0;
          iss_base_nxt = '0;
          chk_vld_nxt  = 1'b0;
          case (bbal_pkg::op_t'(in_op))
            bbal_pkg::OP_WRITE, bbal_pkg::OP_READ: begin
              if ({1'b0, in_block_index} >= size) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = 1'b1;
                out_bit_nxt    = 1'b0;
                out_grant_nxt  = '0;
                out_free_nxt   = fc_r;
              end else begin
                state_nxt = bbal_pkg::ST_SEEK;
              end
            end
            bbal_pkg::OP_ALLOC: begin
              if (fc_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = 1'b1;
                out_bit_nxt    = 1'b0;
                out_grant_nxt  = '0;
                out_free_nxt   = fc_r;
              end else begin
                state_nxt = bbal_pkg::ST_SCAN;
              end
            end
            bbal_pkg::OP_INIT: begin
              res_nxt   = res_lim;
              fc_nxt    = size - res_lim;
              emit_nxt  = 1'b1;
              state_nxt = bbal_pkg::ST_CLR;
            end
            default: begin
              state_nxt = bbal_pkg::ST_IDLE;
            end
          endcase
        end
      end

      bbal_pkg::ST_CLR: begin
        mem_we    = 1'b1;
        mem_wdata = clr_mask;
        if (last_word) begin
          state_nxt = bbal_pkg::ST_IDLE;
          emit_nxt  = 1'b0;
          if (emit_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = 1'b0;
            out_bit_nxt    = 1'b0;
            out_grant_nxt  = '0;
            out_free_nxt   = fc_r;
          end
        end else begin
          iss_w_nxt    = iss_w_r + WW'(1);
          iss_base_nxt = iss_base_r + MWB_C;
        end
      end

      bbal_pkg::ST_SEEK: begin
        if ({1'b0, idx_r} < iss_base_r + MWB_C) begin
          state_nxt = bbal_pkg::ST_RMW;
        end else begin
          iss_w_nxt    = iss_w_r + WW'(1);
          iss_base_nxt = iss_base_r + MWB_C;
        end
      end

      bbal_pkg::ST_RMW: begin
        state_nxt      = bbal_pkg::ST_IDLE;
        out_valid_nxt  = 1'b1;
        out_status_nxt = 1'b0;
        out_grant_nxt  = '0;
        out_free_nxt   = fc_r;
        if (op_r == bbal_pkg::OP_WRITE) begin
          mem_we      = 1'b1;
          mem_wdata   = rmw_word;
          out_bit_nxt = 1'b0;
        end else begin
          out_bit_nxt = rdata_r[bp];
        end
      end

      bbal_pkg::ST_SCAN: begin
        chk_w_nxt    = iss_w_r;
        chk_base_nxt = iss_base_r;
        chk_vld_nxt  = 1'b1;
        if (!last_word) begin
          iss_w_nxt    = iss_w_r + WW'(1);
          iss_base_nxt = iss_base_r + MWB_C;
        end
        if (chk_vld_r) begin
          if (ffz_found) begin
            mem_we         = 1'b1;
            mem_waddr      = chk_w_r;
            mem_wdata      = set_word;
            fc_nxt         = fc_r - CW'(1);
            state_nxt      = bbal_pkg::ST_IDLE;
            out_valid_nxt  = 1'b1;
            out_status_nxt = 1'b0;
            out_bit_nxt    = 1'b0;
            out_grant_nxt  = IW'(chk_base_r + CW'(ffz_pos));
            out_free_nxt   = fc_r - CW'(1);
          end else if (chk_last) begin
            state_nxt      = bbal_pkg::ST_IDLE;
            out_valid_nxt  = 1'b1;
            out_status_nxt = 1'b1;
            out_bit_nxt    = 1'b0;
            out_grant_nxt  = '0;
            out_free_nxt   = fc_r;
          end
        end
      end

      default: begin
        state_nxt = bbal_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bbal_pkg::ST_CLR;
      iss_w_r     <= '0;
      iss_base_r  <= '0;
      chk_vld_r   <= 1'b0;
      res_r       <= '0;
      fc_r        <= '0;
      emit_r      <= 1'b0;
      out_valid_r <= 1'b0;
      total_r     <= bbal_pkg::TOTAL_RST;
      rsv_r       <= bbal_pkg::RESERVED_RST;
    end else begin
      state_r     <= state_nxt;
      iss_w_r     <= iss_w_nxt;
      iss_base_r  <= iss_base_nxt;
      chk_vld_r   <= chk_vld_nxt;
      res_r       <= res_nxt;
      fc_r        <= fc_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (bbal_pkg::reg_idx_t'(cfg_index))
          bbal_pkg::REG_TOTAL:    total_r <= cfg_wdata;
          bbal_pkg::REG_RESERVED: rsv_r   <= cfg_wdata;
          default: begin
            total_r <= total_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    idx_r        <= idx_nxt;
    val_r        <= val_nxt;
    chk_w_r      <= chk_w_nxt;
    chk_base_r   <= chk_base_nxt;
    out_status_r <= out_status_nxt;
    out_bit_r    <= out_bit_nxt;
    out_grant_r  <= out_grant_nxt;
    out_free_r   <= out_free_nxt;
  end

  assign busy                = state_r != bbal_pkg::ST_IDLE;
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_bit_out         = out_bit_r;
  assign out_allocated_block = out_grant_r;
  assign out_free_blocks     = out_free_r;

endmodule

`default_nettype wire

// File: rtl/core/bbal_ffz.sv
// Lowest-set-bit finder over one map word
`default_nettype none

module bbal_ffz #(
  parameter int WIDTH = 32
) (
  input  wire logic [WIDTH-1:0]         vec,
  output logic                          found,
  output logic [$clog2(WIDTH)-1:0]      pos
);

  localparam int PW = $clog2(WIDTH);

  always_comb begin
    found = |vec;
    pos   = '0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (vec[i]) begin
        pos = PW'(i);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/bbal_chk.sv
// Port-level checker for the block bitmap allocator, bound to the top level
`default_nettype none
`include "block_bitmap_allocator_assert.svh"

module bbal_chk (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic                       out_valid,
  input wire logic                       out_status,
  input wire logic                       out_bit_out,
  input wire logic [bbal_pkg::IDX_W-1:0] out_allocated_block
);

  `BBAL_ASSERT_SAME(a_result_when_idle, out_valid, !busy, "result shown while still busy")

  `BBAL_ASSERT_NEXT(a_no_invented_result, !busy && !start, !out_valid, "result without request")

  `BBAL_ASSERT_SAME(a_result_follows_work, out_valid, $past(busy) || $past(start),
                    "result from nowhere")

  `BBAL_ASSERT_SAME(a_fail_fields_zero, out_valid && out_status,
                    !out_bit_out && (out_allocated_block == '0), "failure with payload")

endmodule

bind block_bitmap_allocator bbal_chk u_bbal_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .out_valid           (out_valid),
  .out_status          (out_status),
  .out_bit_out         (out_bit_out),
  .out_allocated_block (out_allocated_block)
);

`default_nettype wire
